// ===== rtl/cmbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmbd_pkg - shared types and constants of the memory bus decoder
// Memory map constants, request descriptor and size helpers.
// ----------------------------------------------------------------------------
package cmbd_pkg;

  localparam int unsigned RAM_BYTES     = 2097152;
  localparam int unsigned SCRATCH_BYTES = 1024;
  localparam int unsigned BANKS         = 4;

  localparam int unsigned RAM_ROWS      = RAM_BYTES / BANKS;
  localparam int unsigned RAM_ROW_W     = $clog2(RAM_ROWS);
  localparam int unsigned SCR_ROWS      = SCRATCH_BYTES / BANKS;
  localparam int unsigned SCR_ROW_W     = $clog2(SCR_ROWS);
  localparam int unsigned RAM_LIMIT_W   = 22;
  localparam int unsigned MIRROR_W      = 21;

  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] PHYS_MASK     = 32'h1FFF_FFFF;
  localparam logic [31:0] MIRROR_MASK   = 32'h001F_FFFF;
  localparam logic [31:0] MIRROR_END    = 32'h0080_0000;
  localparam logic [31:0] SCRATCH_BASE  = 32'h1F80_0000;
  localparam logic [31:0] GPU_GP0       = 32'h1F80_1810;
  localparam logic [31:0] GPU_GP1       = 32'h1F80_1814;

  localparam logic [RAM_LIMIT_W-1:0] RAM_LIMIT_RESET = RAM_LIMIT_W'(RAM_BYTES);

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2
  } size_e;

  typedef enum logic [2:0] {
    TGT_RAM      = 3'd0,
    TGT_SCRATCH  = 3'd1,
    TGT_GP1      = 3'd2,
    TGT_GP0      = 3'd3,
    TGT_UNMAPPED = 3'd4
  } target_e;

  typedef enum logic {
    BK_IDLE   = 1'b0,
    BK_ACCESS = 1'b1
  } back_state_e;

  // Classified request. data holds write data for writes and the shifted,
  // masked GPU status value for GP1 port reads; other reads hold zero.
  typedef struct packed {
    op_e                  op;
    size_e                size;
    target_e              target;
    logic [1:0]           off;
    logic [RAM_ROW_W-1:0] row;
    logic [31:0]          data;
    logic [31:0]          addr;
  } req_t;

  function automatic logic [2:0] size_bytes(input size_e size);
    logic [2:0] n;
    case (size)
      SZ_BYTE: n = 3'd1;
      SZ_HALF: n = 3'd2;
      SZ_WORD: n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [31:0] size_mask(input size_e size);
    logic [31:0] m;
    case (size)
      SZ_BYTE: m = 32'h0000_00FF;
      SZ_HALF: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/cmbd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmbd_front - request intake and address decode
// Holds the RAM limit register, decodes each request to a target and pushes
// the classified request into the queue.
// ----------------------------------------------------------------------------
module cmbd_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cmbd_pkg::RAM_LIMIT_W-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                opcode_i,
  input  logic [1:0]                          access_size_i,
  input  logic [31:0]                         address_i,
  input  logic [31:0]                         write_data_i,
  input  logic [31:0]                         gpu_status_i,
  input  logic                                q_full_i,
  input  logic                                clr_busy_i,
  output logic                                push_o,
  output cmbd_pkg::req_t                      push_req_o
);
  import cmbd_pkg::*;

  logic [RAM_LIMIT_W-1:0] ram_limit_q;
  logic [RAM_LIMIT_W-1:0] eff_size;
  logic [31:0]           phys;
  logic [31:0]           soff;
  logic [MIRROR_W-1:0]   roff;
  logic [MIRROR_W+1:0]   ram_end;
  logic [32:0]           scr_end;
  logic [2:0]            nbytes;
  size_e                 size;
  op_e                   op;
  logic                  sz_ok;
  logic                  ram_hit;
  logic                  scr_hit;
  logic                  in_g0;
  logic                  in_g1;
  logic                  gpu_ok;
  logic [1:0]            po;
  target_e               target;
  logic [31:0]           data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_limit_q <= RAM_LIMIT_RESET;
    end else if (cfg_we_i) begin
      ram_limit_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = !q_full_i && !clr_busy_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    size     = size_e'(access_size_i);
    op       = op_e'(opcode_i);
    nbytes   = size_bytes(size);
    sz_ok    = (nbytes != 3'd0);
    eff_size = (ram_limit_q < RAM_LIMIT_RESET) ? ram_limit_q : RAM_LIMIT_RESET;
    phys     = address_i & PHYS_MASK;
    roff     = MIRROR_W'(phys & MIRROR_MASK);
    soff     = phys - SCRATCH_BASE;
    po       = phys[1:0];

    ram_end  = {2'b00, roff} + (MIRROR_W + 2)'(nbytes);
    scr_end  = {1'b0, soff} + 33'(nbytes);

    ram_hit  = sz_ok && (phys < MIRROR_END) && (eff_size != '0) &&
               (ram_end <= (MIRROR_W + 2)'(eff_size));
    scr_hit  = sz_ok && (phys >= SCRATCH_BASE) && (scr_end <= 33'(SCRATCH_BYTES));
    in_g0    = (phys[31:2] == GPU_GP0[31:2]);
    in_g1    = (phys[31:2] == GPU_GP1[31:2]);
    gpu_ok   = (size == SZ_BYTE) || ((size == SZ_HALF) && !po[0]) ||
               ((size == SZ_WORD) && (po == 2'd0));

    if (ram_hit) begin
      target = TGT_RAM;
    end else if (scr_hit) begin
      target = TGT_SCRATCH;
    end else if (sz_ok && (in_g0 || in_g1) && gpu_ok) begin
      target = in_g1 ? TGT_GP1 : TGT_GP0;
    end else begin
      target = TGT_UNMAPPED;
    end

    if (op == OP_WRITE) begin
      data = write_data_i;
    end else if (target == TGT_GP1) begin
      data = (gpu_status_i >> {po, 3'b000}) & size_mask(size);
    end else begin
      data = '0;
    end

    push_req_o.op     = op;
    push_req_o.size   = size;
    push_req_o.target = target;
    push_req_o.off    = po;
    push_req_o.row    = (target == TGT_SCRATCH) ?
                        RAM_ROW_W'(soff[SCR_ROW_W+1:2]) : roff[RAM_ROW_W+1:2];
    push_req_o.data   = data;
    push_req_o.addr   = address_i;
  end

endmodule

// ===== rtl/cmbd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmbd_queue - request queue between decode and execute
// Small register FIFO of classified requests.
// ----------------------------------------------------------------------------
module cmbd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cmbd_pkg::req_t push_req_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           not_empty_o,
  output cmbd_pkg::req_t head_o
);
  import cmbd_pkg::*;

  req_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_d;
  logic [QCNT_W-1:0] count_q;
  logic [QCNT_W-1:0] count_d;

  assign full_o      = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign head_o      = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

// ===== rtl/cmbd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmbd_back - access execution
// Byte-banked main RAM and scratchpad, unmapped bookkeeping and the
// result register. Clears the scratchpad one row per cycle after reset.
// ----------------------------------------------------------------------------
module cmbd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_not_empty_i,
  input  cmbd_pkg::req_t head_i,
  output logic           pop_o,
  output logic           clr_busy_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [31:0]    read_data_o,
  output logic [2:0]     target_o,
  output logic           gpu_forward_valid_o,
  output logic           gpu_forward_port_o,
  output logic [31:0]    gpu_forward_word_o,
  output logic [31:0]    unmapped_total_o,
  output logic [31:0]    last_unmapped_address_o
);
  import cmbd_pkg::*;

  back_state_e          state_q;
  back_state_e          state_d;
  req_t                 cur_q;
  logic                 load;

  logic                 clr_busy_q;
  logic [SCR_ROW_W-1:0] clr_cnt_q;

  logic [2:0]           nbytes;
  logic [31:0]          wword;
  logic [7:0]           wbyte    [BANKS];
  logic                 bank_act [BANKS];
  logic [RAM_ROW_W-1:0] bank_row [BANKS];
  logic [7:0]           ram_rd_q [BANKS];
  logic [7:0]           scr_rd_q [BANKS];

  logic [31:0]          bank_word;
  logic [31:0]          mem_value;
  logic [31:0]          rd_d;
  logic                 fv_d;
  logic                 out_valid_q;
  logic [31:0]          rd_q;
  target_e              tgt_q;
  logic                 fv_q;
  logic                 fp_q;
  logic [31:0]          fw_q;
  logic [31:0]          cnt_q;
  logic [31:0]          last_q;

  function automatic logic [31:0] rot_left(input logic [31:0] w, input logic [1:0] s);
    logic [63:0] dbl;
    dbl = {w, w} << {s, 3'b000};
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] rot_right(input logic [31:0] w, input logic [1:0] s);
    logic [63:0] dbl;
    dbl = {w, w} >> {s, 3'b000};
    return dbl[31:0];
  endfunction

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        // take a request only once the result register is free and the scratchpad clear is done
        if (q_not_empty_i && !out_valid_q && !clr_busy_q) begin
          pop_o   = 1'b1;
          state_d = BK_ACCESS;
        end
      end
      BK_ACCESS: begin
        load    = 1'b1;
        state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  // ---------------- scratchpad clear ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == SCR_ROW_W'(SCR_ROWS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign clr_busy_o = clr_busy_q;

  // ---------------- lane steering ----------------
  // byte i of the access lives in bank (off + i) mod 4; banks below off
  // belong to the next row.
  always_comb begin
    nbytes = size_bytes(head_i.size);
    wword  = rot_left(head_i.data, head_i.off);
    for (int b = 0; b < BANKS; b++) begin
      wbyte[b]    = wword[8*b +: 8];
      bank_act[b] = ((2'(b) - head_i.off) < nbytes[1:0]) || (nbytes == 3'd4);
      bank_row[b] = head_i.row + RAM_ROW_W'(2'(b) < head_i.off);
    end
  end

  for (genvar gb = 0; gb < BANKS; gb++) begin : g_bank
    logic [7:0]           ram_mem [RAM_ROWS];
    logic [7:0]           scr_mem [SCR_ROWS];
    logic                 ram_we;
    logic                 scr_we;
    logic [SCR_ROW_W-1:0] scr_addr;
    logic [7:0]           scr_wdata;

    assign ram_we    = pop_o && (head_i.target == TGT_RAM) && (head_i.op == OP_WRITE) &&
                       bank_act[gb];
    assign scr_we    = clr_busy_q || (pop_o && (head_i.target == TGT_SCRATCH) &&
                       (head_i.op == OP_WRITE) && bank_act[gb]);
    assign scr_addr  = clr_busy_q ? clr_cnt_q : bank_row[gb][SCR_ROW_W-1:0];
    assign scr_wdata = clr_busy_q ? 8'h00 : wbyte[gb];

    always_ff @(posedge clk_i) begin
      if (ram_we) begin
        ram_mem[bank_row[gb]] <= wbyte[gb];
      end
      if (pop_o) begin
        ram_rd_q[gb] <= ram_mem[bank_row[gb]];
      end
    end

    always_ff @(posedge clk_i) begin
      if (scr_we) begin
        scr_mem[scr_addr] <= scr_wdata;
      end
      if (pop_o) begin
        scr_rd_q[gb] <= scr_mem[scr_addr];
      end
    end
  end

  // ---------------- result ----------------
  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      bank_word[8*b +: 8] = (cur_q.target == TGT_RAM) ? ram_rd_q[b] : scr_rd_q[b];
    end
    mem_value = rot_right(bank_word, cur_q.off) & size_mask(cur_q.size);

    if (cur_q.op == OP_WRITE) begin
      rd_d = '0;
    end else begin
      case (cur_q.target)
        TGT_RAM, TGT_SCRATCH: rd_d = mem_value;
        TGT_GP1:              rd_d = cur_q.data;
        default:              rd_d = '0;
      endcase
    end
    fv_d = (cur_q.op == OP_WRITE) && (cur_q.size == SZ_WORD) &&
           ((cur_q.target == TGT_GP0) || (cur_q.target == TGT_GP1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      last_q      <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load && (cur_q.target == TGT_UNMAPPED)) begin
        cnt_q  <= cnt_q + 1'b1;
        last_q <= cur_q.addr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rd_q  <= rd_d;
      tgt_q <= cur_q.target;
      fv_q  <= fv_d;
      fp_q  <= fv_d && (cur_q.target == TGT_GP1);
      fw_q  <= fv_d ? cur_q.data : 32'h0;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign read_data_o             = rd_q;
  assign target_o                = tgt_q;
  assign gpu_forward_valid_o     = fv_q;
  assign gpu_forward_port_o      = fp_q;
  assign gpu_forward_word_o      = fw_q;
  assign unmapped_total_o        = cnt_q;
  assign last_unmapped_address_o = last_q;

endmodule

// ===== rtl/console_memory_bus_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_memory_bus_decoder - console memory map bus decoder
// Decodes processor bus requests to main RAM, scratchpad, GPU ports or
// unmapped space and returns one result per request.
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  s_axis    in   tuser: opcode; tdata: access_size, address, write_data,
//                 gpu_status
//  m_axis    out  tuser: target; tdata: read_data, gpu_forward_valid,
//                 gpu_forward_port, gpu_forward_word, unmapped_total,
//                 last_unmapped_address
//  cfg       in   cfg_we_i / cfg_wdata_i: RAM limit in bytes
//
//  A request passes from intake to result through the queue entry, the
//  registered banked memory read and the result register.
//  The execute side handles one request at a time and waits for the result
//  to be taken before it takes the next; up to two decoded requests wait
//  in the queue.
//  After reset the scratchpad is cleared row by row; s_axis_tready_o
//  stays low meanwhile. Main RAM holds no reset value.
//  An unconsumed result holds the execute side; intake goes on until the
//  queue is full.
// ----------------------------------------------------------------------------
module console_memory_bus_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cmbd_pkg::RAM_LIMIT_W-1:0] cfg_wdata_i,     // RAM limit in bytes
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [103:0]                     s_axis_tdata_i,  // access_size, address,
                                                            // write_data, gpu_status
  input  logic [0:0]                       s_axis_tuser_i,  // opcode
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [135:0]                     m_axis_tdata_o,  // read_data, fwd_valid,
                                                            // fwd_port, fwd_word,
                                                            // unmapped_total,
                                                            // last_unmapped_address
  output logic [2:0]                       m_axis_tuser_o   // target
);
  import cmbd_pkg::*;

  logic        push;
  req_t        push_req;
  logic        q_full;
  logic        q_not_empty;
  logic        pop;
  req_t        head;
  logic        clr_busy;
  logic [31:0] read_data;
  logic        fwd_valid;
  logic        fwd_port;
  logic [31:0] fwd_word;
  logic [31:0] unmapped_total;
  logic [31:0] last_unmapped;

  cmbd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .opcode_i      (s_axis_tuser_i[0]),
    .access_size_i (s_axis_tdata_i[1:0]),
    .address_i     (s_axis_tdata_i[33:2]),
    .write_data_i  (s_axis_tdata_i[65:34]),
    .gpu_status_i  (s_axis_tdata_i[97:66]),
    .q_full_i      (q_full),
    .clr_busy_i    (clr_busy),
    .push_o        (push),
    .push_req_o    (push_req)
  );

  cmbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_req_i  (push_req),
    .full_o      (q_full),
    .pop_i       (pop),
    .not_empty_o (q_not_empty),
    .head_o      (head)
  );

  cmbd_back u_back (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .q_not_empty_i           (q_not_empty),
    .head_i                  (head),
    .pop_o                   (pop),
    .clr_busy_o              (clr_busy),
    .out_valid_o             (m_axis_tvalid_o),
    .out_ready_i             (m_axis_tready_i),
    .read_data_o             (read_data),
    .target_o                (m_axis_tuser_o),
    .gpu_forward_valid_o     (fwd_valid),
    .gpu_forward_port_o      (fwd_port),
    .gpu_forward_word_o      (fwd_word),
    .unmapped_total_o        (unmapped_total),
    .last_unmapped_address_o (last_unmapped)
  );

  assign m_axis_tdata_o = {6'b0, last_unmapped, unmapped_total, fwd_word,
                           fwd_port, fwd_valid, read_data};

  // ---------------- assertions ----------------
  a_no_intake_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !s_axis_tready_o && !pop
  ) else $error("request taken while scratchpad clear in progress");

  a_forward_only_to_gpu : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && fwd_valid) |->
      ((m_axis_tuser_o == TGT_GP0) || (m_axis_tuser_o == TGT_GP1))
  ) else $error("GPU forward flagged on a non-GPU target");

  a_forward_fields_clean : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !fwd_valid) |-> (fwd_word == 32'h0) && !fwd_port
  ) else $error("forward port or word set without a forward");

  a_pop_needs_entry : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_not_empty && !m_axis_tvalid_o
  ) else $error("execute took a request without queue entry or free result slot");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for console_memory_bus_decoder
// Drives bus requests on s_axis and predicts each result with a local model
// of the memory map (RAM mirrors and bounds, scratchpad, GPU ports, unmapped
// tracking). Results on m_axis are compared in order, field by field.
// ----------------------------------------------------------------------------
module tb;
  import cmbd_pkg::*;

  localparam int          STALL_LIMIT = 5000;
  localparam logic [1:0]  SZ_NONE     = 2'd3;   // size code that maps nothing
  localparam logic [31:0] GPU_STS     = 32'hA5C3_E187;

  typedef struct packed {
    op_e         op;
    logic [1:0]  size;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [31:0] status;
  } access_t;

  typedef struct packed {
    logic [31:0] rdata;
    target_e     target;
    logic        fwd_valid;
    logic        fwd_port;
    logic [31:0] fwd_word;
    logic [31:0] unmapped_total;
    logic [31:0] last_unmapped;
  } outcome_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [RAM_LIMIT_W-1:0] cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [103:0]           s_tdata = '0;
  logic [0:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [135:0]           m_tdata;
  logic [2:0]             m_tuser;

  // decoder model state
  logic [RAM_LIMIT_W-1:0] ram_limit_cfg;
  logic [7:0]             ram_mem [int unsigned];
  logic [7:0]             scratch_mem [SCRATCH_BYTES];
  logic [31:0]            unmapped_count;
  logic [31:0]            unmapped_addr;
  int unsigned            ram_offsets [$];

  outcome_t              pending_results [$];
  int unsigned           requests_sent;
  int unsigned           results_seen;
  int unsigned           errors;
  int unsigned           target_hits [5];
  int unsigned           forwarded;
  int unsigned           src_idle_pct;
  int unsigned           sink_idle_pct;
  int unsigned           hold_req;
  int unsigned           stall_cycles;

  console_memory_bus_decoder u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned access_bytes(logic [1:0] size);
    case (size)
      SZ_BYTE: return 1;
      SZ_HALF: return 2;
      SZ_WORD: return 4;
      default: return 0;
    endcase
  endfunction

  function automatic target_e classify(access_t a);
    int unsigned n;
    int unsigned eff;
    logic [31:0] phys;
    logic [31:0] roff;
    logic [31:0] soff;
    logic        in_gp0;
    logic        in_gp1;
    logic        size_ok;
    n       = access_bytes(a.size);
    phys    = a.addr & PHYS_MASK;
    roff    = phys & MIRROR_MASK;
    soff    = phys - SCRATCH_BASE;
    eff     = (ram_limit_cfg < RAM_BYTES) ? ram_limit_cfg : RAM_BYTES;
    in_gp0  = phys[31:2] == GPU_GP0[31:2];
    in_gp1  = phys[31:2] == GPU_GP1[31:2];
    size_ok = (n == 1) || (n == 2 && !phys[0]) || (n == 4 && phys[1:0] == 2'b00);
    if (n == 0) return TGT_UNMAPPED;
    // bounds use offset plus size, so an access straddling the end misses RAM
    if (phys < MIRROR_END && eff != 0 && roff + n <= eff) return TGT_RAM;
    if (phys >= SCRATCH_BASE && soff + n <= SCRATCH_BYTES) return TGT_SCRATCH;
    if ((in_gp0 || in_gp1) && size_ok) return in_gp1 ? TGT_GP1 : TGT_GP0;
    return TGT_UNMAPPED;
  endfunction

  // RAM has no reset value: a read touching a never-written byte is illegal
  function automatic bit ram_read_undefined(access_t a);
    logic [31:0] roff;
    roff = a.addr & MIRROR_MASK;
    if (classify(a) != TGT_RAM) return 1'b0;
    for (int i = 0; i < access_bytes(a.size); i++)
      if (!ram_mem.exists(roff + i)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic outcome_t decode_access(access_t a);
    outcome_t    o;
    int unsigned n;
    logic [31:0] phys;
    logic [31:0] roff;
    logic [31:0] soff;
    logic [31:0] lane_mask;
    n    = access_bytes(a.size);
    phys = a.addr & PHYS_MASK;
    roff = phys & MIRROR_MASK;
    soff = phys - SCRATCH_BASE;
    o    = '0;
    o.target = classify(a);
    case (o.target)
      TGT_RAM: begin
        if (a.op == OP_WRITE) ram_offsets.push_back(roff);
        for (int i = 0; i < n; i++)
          if (a.op == OP_WRITE) ram_mem[roff + i] = a.wdata[8*i +: 8];
          else o.rdata[8*i +: 8] = ram_mem[roff + i];
      end
      TGT_SCRATCH: begin
        for (int i = 0; i < n; i++)
          if (a.op == OP_WRITE) scratch_mem[soff + i] = a.wdata[8*i +: 8];
          else o.rdata[8*i +: 8] = scratch_mem[soff + i];
      end
      TGT_GP0, TGT_GP1: begin
        lane_mask = (n == 1) ? 32'h0000_00FF : (n == 2) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
        if (a.op == OP_READ) begin
          if (o.target == TGT_GP1) o.rdata = (a.status >> (8 * phys[1:0])) & lane_mask;
        end else if (n == 4) begin
          // only full words reach the GPU, narrower writes are dropped
          o.fwd_valid = 1'b1;
          o.fwd_port  = (o.target == TGT_GP1);
          o.fwd_word  = a.wdata;
        end
      end
      default: begin
        unmapped_addr  = a.addr;
        unmapped_count = unmapped_count + 1;
      end
    endcase
    if (a.op == OP_WRITE) o.rdata = '0;
    o.unmapped_total = unmapped_count;
    o.last_unmapped  = unmapped_addr;
    return o;
  endfunction

  function automatic access_t mk(op_e op, logic [1:0] size, logic [31:0] addr,
                                 logic [31:0] wdata, logic [31:0] status);
    access_t a;
    a.op     = op;
    a.size   = size;
    a.addr   = addr;
    a.wdata  = wdata;
    a.status = status;
    return a;
  endfunction

  function automatic access_t random_access();
    access_t     a;
    int unsigned pick;
    int unsigned off;
    int unsigned eff;
    a.op     = op_e'($urandom_range(1));
    a.size   = 2'($urandom_range(2));
    a.addr   = $urandom;
    a.wdata  = $urandom;
    a.status = $urandom;
    eff      = ram_limit_cfg;
    pick     = $urandom_range(99);
    if (pick < 35) begin
      // RAM: reads mostly revisit bytes already written
      if (a.op == OP_READ && ram_offsets.size() != 0 && $urandom_range(4) != 0) begin
        off = ram_offsets[$urandom_range(ram_offsets.size() - 1)];
      end else begin
        case ($urandom_range(9))
          0:       off = (eff >= 4) ? eff - $urandom_range(4, 1) : $urandom_range(3);
          1:       off = $urandom_range(MIRROR_MASK);
          2, 3, 4: off = $urandom_range(63);
          default: off = (eff != 0) ? $urandom_range(eff - 1) : $urandom_range(1023);
        endcase
      end
      a.addr = {a.addr[31:29], 29'(($urandom_range(3) << 21) | off)};
      if (a.op == OP_READ && ram_read_undefined(a)) a.size = SZ_BYTE;
    end else if (pick < 55) begin
      case ($urandom_range(9))
        0:       off = $urandom_range(1023, 1020);
        1:       off = $urandom_range(4095, 1024);
        default: off = $urandom_range(1023);
      endcase
      a.addr = {a.addr[31:29], 29'(SCRATCH_BASE + off)};
    end else if (pick < 75) begin
      a.addr = {a.addr[31:29], 29'(GPU_GP0 - 4 + $urandom_range(15))};
    end
    return a;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_access(input access_t a);
    outcome_t o;
    if (a.op == OP_READ && ram_read_undefined(a)) a.op = OP_WRITE;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, a.status, a.wdata, a.addr, a.size};
    s_tuser  <= a.op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    o = decode_access(a);
    pending_results.push_back(o);
    requests_sent++;
    target_hits[o.target]++;
    if (o.fwd_valid) forwarded++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_ram_limit(input logic [RAM_LIMIT_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    ram_limit_cfg = value;
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 100)
      $display("mismatch on result %0d: %s got %h expected %h", results_seen, what, got, want);
  endtask

  task automatic test_directed();
    src_idle_pct  = 30;
    sink_idle_pct = 79;
    // RAM: mirrors, segments, little-endian lanes, top of RAM
    send_access(mk(OP_WRITE, SZ_WORD, 32'h0000_0000, 32'hDEAD_BEEF, 32'h0));
    send_access(mk(OP_READ,  SZ_WORD, 32'h8000_0000, 32'h0, 32'h0));
    send_access(mk(OP_READ,  SZ_BYTE, 32'hA060_0003, 32'h0, 32'h0));
    send_access(mk(OP_READ,  SZ_HALF, 32'h0020_0002, 32'h0, 32'h0));
    send_access(mk(OP_WRITE, SZ_HALF, 32'h001F_FFFE, 32'h1234_ABCD, 32'h0));
    send_access(mk(OP_READ,  SZ_HALF, 32'hE01F_FFFE, 32'h0, 32'h0));
    send_access(mk(OP_WRITE, SZ_WORD, 32'h001F_FFFE, 32'hFFFF_FFFF, 32'h0));
    send_access(mk(OP_READ,  SZ_WORD, 32'h0080_0000, 32'h0, 32'h0));
    // scratchpad: cleared contents, last word, straddling the end
    send_access(mk(OP_WRITE, SZ_WORD, 32'h1F80_0000, 32'hFFFF_FFFF, 32'h0));
    send_access(mk(OP_READ,  SZ_HALF, 32'h9F80_0002, 32'h0, 32'h0));
    send_access(mk(OP_READ,  SZ_BYTE, 32'h1F80_03FF, 32'h0, 32'h0));
    send_access(mk(OP_WRITE, SZ_WORD, 32'h1F80_03FC, 32'h8765_4321, 32'h0));
    send_access(mk(OP_READ,  SZ_WORD, 32'hBF80_03FE, 32'h0, 32'h0));
    // GPU ports: status lanes, odd halfword, forwarding, dropped narrow writes
    send_access(mk(OP_READ,  SZ_WORD, 32'h1F80_1814, 32'h0, GPU_STS));
    send_access(mk(OP_READ,  SZ_BYTE, 32'h1F80_1817, 32'h0, GPU_STS));
    send_access(mk(OP_READ,  SZ_HALF, 32'h1F80_1816, 32'h0, GPU_STS));
    send_access(mk(OP_READ,  SZ_HALF, 32'h1F80_1815, 32'h0, GPU_STS));
    send_access(mk(OP_READ,  SZ_WORD, 32'h1F80_1810, 32'h0, 32'hFFFF_FFFF));
    send_access(mk(OP_WRITE, SZ_WORD, 32'h1F80_1810, 32'hFFFF_FFFF, GPU_STS));
    send_access(mk(OP_WRITE, SZ_WORD, 32'hBF80_1814, 32'h0800_0001, GPU_STS));
    send_access(mk(OP_WRITE, SZ_HALF, 32'h1F80_1812, 32'h1111_2222, GPU_STS));
    send_access(mk(OP_WRITE, SZ_BYTE, 32'h1F80_1815, 32'h3333_4444, GPU_STS));
    send_access(mk(OP_READ,  SZ_WORD, 32'h1F80_1812, 32'h0, GPU_STS));
    // reserved size code and the top of the address space
    send_access(mk(OP_READ,  SZ_NONE, 32'h1F80_0000, 32'h0, 32'h0));
    send_access(mk(OP_READ,  SZ_BYTE, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
    // no RAM at all, then a four-byte RAM
    write_ram_limit('0);
    send_access(mk(OP_READ,  SZ_WORD, 32'h0000_0000, 32'h0, 32'h0));
    write_ram_limit(RAM_LIMIT_W'(4));
    send_access(mk(OP_READ,  SZ_WORD, 32'h0000_0000, 32'h0, 32'h0));
    send_access(mk(OP_READ,  SZ_BYTE, 32'h0000_0004, 32'h0, 32'h0));
    drain_results();
  endtask

  task automatic test_random_traffic(input int unsigned count,
                                     input logic [RAM_LIMIT_W-1:0] ram_bytes,
                                     input int unsigned src_pct, input int unsigned sink_pct);
    write_ram_limit(ram_bytes);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (count) send_access(random_access());
    drain_results();
  endtask

  // long output stall fills the queue and pushes back on the request side
  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    @(posedge clk);
    hold_req = 300;
    @(negedge clk);
    repeat (40) send_access(random_access());
    drain_results();
    repeat (20) send_access(random_access());
    drain_results();
  endtask

  // result sink: random stalls plus requested hold-off stretches
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending, read_data", m_tdata[31:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[31:0] !== want.rdata)
          report_mismatch("read_data", m_tdata[31:0], want.rdata);
        if (m_tuser !== want.target)
          report_mismatch("target", 32'(m_tuser), 32'(want.target));
        if (m_tdata[32] !== want.fwd_valid)
          report_mismatch("gpu_forward_valid", 32'(m_tdata[32]), 32'(want.fwd_valid));
        if (m_tdata[33] !== want.fwd_port)
          report_mismatch("gpu_forward_port", 32'(m_tdata[33]), 32'(want.fwd_port));
        if (m_tdata[65:34] !== want.fwd_word)
          report_mismatch("gpu_forward_word", m_tdata[65:34], want.fwd_word);
        if (m_tdata[97:66] !== want.unmapped_total)
          report_mismatch("unmapped_total", m_tdata[97:66], want.unmapped_total);
        if (m_tdata[129:98] !== want.last_unmapped)
          report_mismatch("last_unmapped_address", m_tdata[129:98], want.last_unmapped);
      end
    end
  end

  // watchdog: ends the run when neither side moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no request or result moved for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    ram_limit_cfg  = RAM_LIMIT_RESET;
    unmapped_count = '0;
    unmapped_addr  = '0;
    foreach (scratch_mem[i]) scratch_mem[i] = '0;
    foreach (target_hits[i]) target_hits[i] = 0;
    requests_sent  = 0;
    results_seen   = 0;
    errors         = 0;
    forwarded      = 0;
    src_idle_pct   = 0;
    sink_idle_pct  = 0;
    hold_req       = 0;
    stall_cycles   = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic(400, RAM_LIMIT_W'(RAM_BYTES), 30, 79);
    test_random_traffic(350, RAM_LIMIT_W'($urandom_range(RAM_BYTES - 1, 1)), 79, 30);
    test_random_traffic(250, '0, 0, 0);
    test_random_traffic(250, RAM_LIMIT_W'(1024), 0, 0);
    test_random_traffic(300, RAM_LIMIT_W'(RAM_BYTES), 0, 0);
    test_backpressure();
    drain_results();
    repeat (10) @(posedge clk);

    $display("%0d requests, %0d results; ram sizes 0, 4, 1024, random and full, %s",
             requests_sent, results_seen, "with stalls on either side and a long output hold");
    $display("ram %0d, scratchpad %0d, gp1 %0d, gp0 %0d, unmapped %0d, forwarded words %0d",
             target_hits[TGT_RAM], target_hits[TGT_SCRATCH], target_hits[TGT_GP1],
             target_hits[TGT_GP0], target_hits[TGT_UNMAPPED], forwarded);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cmbd_pkg.sv
rtl/cmbd_front.sv
rtl/cmbd_queue.sv
rtl/cmbd_back.sv
rtl/console_memory_bus_decoder.sv
tb/sv/tb.sv
